// ===== design/iow_pkg.sv =====
// Shared types and constants for the interval overlap window block.
`timescale 1ns / 1ps
package iow_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned ChromW = 8;
  localparam int unsigned IdW    = 32;
  localparam int unsigned FracW  = 17;
  localparam int unsigned CountW = 7;
  localparam int unsigned QBits  = 16;
  localparam int unsigned StepW  = 4;

  localparam logic [FracW-1:0]  FRAC_ONE  = 17'h10000;
  localparam logic [FracW-1:0]  FRAC_ZERO = 17'h00000;
  localparam logic [StepW-1:0]  STEP_LAST = 4'(QBits - 1);
  localparam logic [IdW-1:0]    ID_FIRST  = 32'd1;

  typedef struct packed {
    logic              new_set;
    logic [CoordW-1:0] seg_start;
    logic [CoordW-1:0] seg_end;
    logic [ChromW-1:0] chromosome;
  } iow_in_t;

  typedef struct packed {
    logic [IdW-1:0]    overlap_id;
    logic [FracW-1:0]  fraction;
    logic [CountW-1:0] run_count;
    logic [IdW-1:0]    list_start;
    logic              last;
    logic              window_overflow;
  } iow_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clr_scan;
    logic count_hit;
    logic next_entry;
    logic div_load;
    logic div_step;
    logic emit_hit;
    logic emit_self;
  } iow_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic scan_end;
    logic div_last;
    logic out_free;
  } iow_sts_t;

endpackage

// ===== design/iow_ctrl.sv =====
// Controller state machine that sequences the two window scans and the result emission.
`timescale 1ns / 1ps
module iow_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              seg_valid,
  output logic              seg_ready,
  input  iow_pkg::iow_sts_t sts,
  output iow_pkg::iow_cmd_t cmd
);
  import iow_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD1, ST_CMP1, ST_RD2, ST_CMP2, ST_DIV, ST_EMITH, ST_EMITS
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (seg_valid) begin
          cmd.load_item = 1'b1;
          cmd.clr_scan  = 1'b1;
          state_next    = ST_RD1;
        end
      end
      ST_RD1: begin
        if (sts.scan_end) begin
          cmd.clr_scan = 1'b1;
          state_next   = ST_RD2;
        end else begin
          state_next = ST_CMP1;
        end
      end
      ST_CMP1: begin
        cmd.count_hit  = sts.hit;
        cmd.next_entry = 1'b1;
        state_next     = ST_RD1;
      end
      ST_RD2: begin
        state_next = sts.scan_end ? ST_EMITS : ST_CMP2;
      end
      ST_CMP2: begin
        if (sts.hit) begin
          cmd.div_load = 1'b1;
          state_next   = ST_DIV;
        end else begin
          cmd.next_entry = 1'b1;
          state_next     = ST_RD2;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_EMITH;
      end
      ST_EMITH: begin
        if (sts.out_free) begin
          cmd.emit_hit   = 1'b1;
          cmd.next_entry = 1'b1;
          state_next     = ST_RD2;
        end
      end
      ST_EMITS: begin
        if (sts.out_free) begin
          cmd.emit_self = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_ready <= 1'b1;
    end else begin
      state     <= state_next;
      seg_ready <= (state_next == ST_IDLE);
    end
  end

endmodule

// ===== design/iow_dp.sv =====
// Datapath: window memory, scan counters, serial divider and result register.
`timescale 1ns / 1ps
module iow_dp #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  iow_pkg::iow_in_t  seg,
  input  iow_pkg::iow_cmd_t cmd,
  output iow_pkg::iow_sts_t sts,
  output logic              hit_valid,
  input  logic              hit_ready,
  output iow_pkg::iow_out_t hit
);
  import iow_pkg::*;

  localparam int unsigned IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_DEPTH);

  typedef struct packed {
    logic [CoordW-1:0] s;
    logic [CoordW-1:0] e;
    logic [ChromW-1:0] c;
  } entry_t;

  entry_t mem [WINDOW_DEPTH];
  entry_t rd_q;

  iow_in_t           item;
  logic [IW-1:0]     head;
  logic [FW-1:0]     fill, k, hits;
  logic [IdW-1:0]    base_id, next_id, list_next;
  logic [CoordW-1:0] rem, dlen;
  logic [QBits-1:0]  quo;
  logic [StepW-1:0]  step;
  logic              dfull;

  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [FW-1:0] b);
    logic [FW:0] s;
    s = (FW+1)'(a) + (FW+1)'(b);
    if (s >= (FW+1)'(WINDOW_DEPTH)) s = s - (FW+1)'(WINDOW_DEPTH);
    return s[IW-1:0];
  endfunction

  // Overlap test of the registered window entry against the held segment.
  logic [CoordW-1:0] lo, hi, ov, len;
  logic              hit_now;
  always_comb begin
    lo      = (rd_q.s > item.seg_start) ? rd_q.s : item.seg_start;
    hi      = (rd_q.e < item.seg_end) ? rd_q.e : item.seg_end;
    ov      = hi - lo;
    len     = item.seg_end - item.seg_start;
    hit_now = (rd_q.c == item.chromosome) && (item.seg_end > item.seg_start) && (hi > lo);
  end

  logic [CoordW:0]   rem2;
  logic              sub_ok;
  logic [FracW-1:0]  frac;
  logic [CountW-1:0] run_cnt;
  logic              ovf;
  logic [IW-1:0]     wr_addr;
  always_comb begin
    rem2    = {rem, 1'b0};
    sub_ok  = rem2 >= {1'b0, dlen};
    frac    = dfull ? FRAC_ONE : ({1'b0, quo} + FracW'(rem != '0));
    run_cnt = CountW'(hits) + CountW'(1);
    ovf     = (hits != '0) && (fill == FILL_FULL);
    if (hits == '0 || fill == FILL_FULL) wr_addr = head;
    else                                 wr_addr = wrap_add(head, fill);
  end

  assign sts.hit      = hit_now;
  assign sts.scan_end = (k == fill);
  assign sts.div_last = (step == STEP_LAST);
  assign sts.out_free = !hit_valid || hit_ready;

  // Window memory: one registered read, one write at commit.
  always_ff @(posedge clk) begin
    rd_q <= mem[wrap_add(head, k)];
    if (cmd.emit_self) mem[wr_addr] <= '{item.seg_start, item.seg_end, item.chromosome};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      k         <= '0;
      hits      <= '0;
      base_id   <= ID_FIRST;
      next_id   <= ID_FIRST;
      list_next <= ID_FIRST;
      hit_valid <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        item <= seg;
        hits <= '0;
        if (seg.new_set) begin
          fill      <= '0;
          base_id   <= ID_FIRST;
          next_id   <= ID_FIRST;
          list_next <= ID_FIRST;
        end
      end
      if (cmd.clr_scan) k <= '0;
      else if (cmd.next_entry) k <= k + FW'(1);
      if (cmd.count_hit) hits <= hits + FW'(1);

      if (cmd.div_load) begin
        rem   <= ov;
        dlen  <= len;
        dfull <= (ov >= len);
        step  <= '0;
      end else if (cmd.div_step) begin
        rem  <= sub_ok ? CoordW'(rem2 - {1'b0, dlen}) : rem2[CoordW-1:0];
        quo  <= {quo[QBits-2:0], sub_ok};
        step <= step + StepW'(1);
      end

      if (cmd.emit_hit || cmd.emit_self) hit_valid <= 1'b1;
      else if (hit_ready) hit_valid <= 1'b0;

      if (cmd.emit_hit) begin
        hit <= '{base_id + IdW'(k), frac, run_cnt, list_next, 1'b0, ovf};
      end

      if (cmd.emit_self) begin
        hit <= '{next_id, FRAC_ZERO, run_cnt, list_next, 1'b1, ovf};
        if (hits == '0) begin
          head    <= wr_addr;
          fill    <= FW'(1);
          base_id <= next_id;
        end else if (fill == FILL_FULL) begin
          head    <= wrap_add(head, FW'(1));
          base_id <= base_id + IdW'(1);
        end else begin
          fill <= fill + FW'(1);
        end
        next_id   <= next_id + IdW'(1);
        list_next <= list_next + IdW'(run_cnt);
      end
    end
  end

endmodule

// ===== design/interval_overlap_window.sv =====
// Top level of the interval overlap window: controller plus datapath.
`timescale 1ns / 1ps
// Each accepted segment transaction is compared, oldest first, with a window of up to
// WINDOW_DEPTH earlier segments held in a circular memory. For every window entry on the
// same chromosome with positive overlap, one result transaction carries that entry's id and
// the overlapped fraction of the new segment's length in Q16 (rounded up, 65536 is 1.0);
// a closing self entry with last set follows. Every result of a run carries the run count,
// the list offset and the overflow flag, so the window is scanned twice: a first pass counts
// the hits (one memory read and one compare per entry), a second pass reads each entry
// again and runs a bit-serial divider for each hit, then emits its result. Each emission
// waits while the result side stalls. The result register lets the last result wait while
// the next segment is accepted. The window needs no clearing after reset.
module interval_overlap_window #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              seg_valid,
  output logic              seg_ready,
  input  iow_pkg::iow_in_t  seg,
  output logic              hit_valid,
  input  logic              hit_ready,
  output iow_pkg::iow_out_t hit
);
  import iow_pkg::*;

  iow_cmd_t cmd;
  iow_sts_t sts;

  // The controller only sequences; all state of the window lives in the datapath.
  iow_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iow_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .seg       (seg),
    .cmd       (cmd),
    .sts       (sts),
    .hit_valid (hit_valid),
    .hit_ready (hit_ready),
    .hit       (hit)
  );

endmodule
